### hw/rtl/ets_pkg.sv
// ets_pkg: shared types and constants for the euler totient sieve unit
// holds the controller states and the command and status structs
// no dependencies
`default_nettype none

package ets_pkg;

    localparam int DATA_W  = 10;
    localparam int FIELD_W = 10;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_INIT,
        ST_SCAN_RD,
        ST_SCAN_TEST,
        ST_MUL_CHK,
        ST_MUL_START,
        ST_MUL_DIV,
        ST_MUL_WR,
        ST_FETCH_LIM,
        ST_RESP_OK,
        ST_RESP_ERR
    } ets_state_t;

    typedef struct packed {
        logic load_item;
        logic init_write;
        logic set_k2;
        logic rd_k;
        logic wr_prime;
        logic next_k;
        logic rd_m;
        logic div_start;
        logic wr_mult;
        logic rd_lim;
        logic rd_idx;
        logic set_built;
        logic out_ok;
        logic out_err;
    } ets_cmd_t;

    typedef struct packed {
        logic is_query;
        logic lim_zero;
        logic idx_bad;
        logic k_eq_lim;
        logic k_le_lim;
        logic m_le_lim;
        logic rdata_eq_k;
        logic div_done;
        logic out_free;
    } ets_status_t;

endpackage

`default_nettype wire

### hw/rtl/ets_div.sv
// ets_div: iterative restoring divider, one quotient bit per cycle
// depends on ets_pkg
`default_nettype none

module ets_div
    import ets_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [DATA_W-1:0] dividend,
    input  wire logic [DATA_W-1:0] divisor,
    output logic                   done,
    output logic [DATA_W-1:0]      quotient
);

    localparam int CW = $clog2(DATA_W + 1);

    logic [DATA_W:0]   rem_reg, rem_next;
    logic [DATA_W-1:0] quo_reg, quo_next;
    logic [DATA_W-1:0] dsr_reg, dsr_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DATA_W:0]   rem_sh;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        rem_sh    = {rem_reg[DATA_W-1:0], quo_reg[DATA_W-1]};
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            if (rem_sh >= {1'b0, dsr_reg})
            begin
                rem_next = rem_sh - {1'b0, dsr_reg};
                quo_next = {quo_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                quo_next = {quo_reg[DATA_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(DATA_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

### hw/rtl/ets_ctrl.sv
// ets_ctrl: state machine that sequences table fill, sieve walk and queries
// depends on ets_pkg
`default_nettype none

module ets_ctrl
    import ets_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire ets_status_t status,
    output ets_cmd_t         cmd
);

    ets_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (status.is_query)
                begin
                    if (status.idx_bad)
                        state_next = ST_RESP_ERR;
                    else
                    begin
                        cmd.rd_idx = 1'b1;
                        state_next = ST_RESP_OK;
                    end
                end
                else if (status.lim_zero)
                begin
                    cmd.set_built = 1'b1;
                    state_next    = ST_RESP_ERR;
                end
                else
                    state_next = ST_INIT;
            end
            ST_INIT:
            begin
                cmd.init_write = 1'b1;
                if (status.k_eq_lim)
                begin
                    cmd.set_k2 = 1'b1;
                    state_next = ST_SCAN_RD;
                end
            end
            ST_SCAN_RD:
            begin
                if (status.k_le_lim)
                begin
                    cmd.rd_k   = 1'b1;
                    state_next = ST_SCAN_TEST;
                end
                else
                    state_next = ST_FETCH_LIM;
            end
            ST_SCAN_TEST:
            begin
                if (status.rdata_eq_k)
                begin
                    cmd.wr_prime = 1'b1;
                    state_next   = ST_MUL_CHK;
                end
                else
                begin
                    cmd.next_k = 1'b1;
                    state_next = ST_SCAN_RD;
                end
            end
            ST_MUL_CHK:
            begin
                if (status.m_le_lim)
                begin
                    cmd.rd_m   = 1'b1;
                    state_next = ST_MUL_START;
                end
                else
                begin
                    cmd.next_k = 1'b1;
                    state_next = ST_SCAN_RD;
                end
            end
            ST_MUL_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_MUL_DIV;
            end
            ST_MUL_DIV:
            begin
                if (status.div_done)
                    state_next = ST_MUL_WR;
            end
            ST_MUL_WR:
            begin
                cmd.wr_mult = 1'b1;
                state_next  = ST_MUL_CHK;
            end
            ST_FETCH_LIM:
            begin
                cmd.rd_lim    = 1'b1;
                cmd.set_built = 1'b1;
                state_next    = ST_RESP_OK;
            end
            ST_RESP_OK:
            begin
                if (status.out_free)
                begin
                    cmd.out_ok = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_RESP_ERR:
            begin
                if (status.out_free)
                begin
                    cmd.out_err = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

### hw/rtl/ets_dp.sv
// ets_dp: datapath with the totient table, sieve counters and output register
// depends on ets_pkg and ets_div
`default_nettype none

module ets_dp
    import ets_pkg::*;
#(
    parameter int LIM_MAX = 1023
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ets_cmd_t           cmd,
    output ets_status_t             status,
    input  wire logic               in_op,
    input  wire logic [FIELD_W-1:0] in_limit,
    input  wire logic [FIELD_W-1:0] in_index,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [DATA_W-1:0]       out_phi,
    output logic                    out_err
);

    localparam int DEPTH = LIM_MAX + 1;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int KW    = AW + 1;

    logic [DATA_W-1:0]  mem [DEPTH];
    logic [DATA_W-1:0]  rdata_reg;
    logic               op_reg;
    logic [AW-1:0]      lim_reg;
    logic [FIELD_W-1:0] idx_reg;
    logic [AW-1:0]      built_reg;
    logic [KW-1:0]      k_reg;
    logic [KW-1:0]      m_reg;
    logic               ov_reg;
    logic [DATA_W-1:0]  phi_reg;
    logic               err_reg;

    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [DATA_W-1:0]  wr_data;
    logic [AW-1:0]      lim_sat;
    logic [DATA_W-1:0]  quotient;
    logic               div_done;

    assign lim_sat = (in_limit > FIELD_W'(LIM_MAX)) ? AW'(LIM_MAX) : in_limit[AW-1:0];

    ets_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (rdata_reg),
        .divisor  (DATA_W'(k_reg)),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb
    begin
        rd_en   = cmd.rd_k | cmd.rd_m | cmd.rd_lim | cmd.rd_idx;
        rd_addr = lim_reg;
        if (cmd.rd_k)
            rd_addr = k_reg[AW-1:0];
        else if (cmd.rd_m)
            rd_addr = m_reg[AW-1:0];
        else if (cmd.rd_idx)
            rd_addr = idx_reg[AW-1:0];
        wr_en   = cmd.init_write | cmd.wr_prime | cmd.wr_mult;
        wr_addr = k_reg[AW-1:0];
        wr_data = DATA_W'(k_reg);
        if (cmd.wr_prime)
            wr_data = DATA_W'(k_reg) - 1'b1;
        else if (cmd.wr_mult)
        begin
            wr_addr = m_reg[AW-1:0];
            wr_data = rdata_reg - quotient;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg  <= in_op;
            lim_reg <= lim_sat;
            idx_reg <= in_index;
        end
        if (cmd.load_item)
            k_reg <= '0;
        else if (cmd.set_k2)
            k_reg <= KW'(2);
        else if (cmd.init_write || cmd.next_k)
            k_reg <= k_reg + 1'b1;
        if (cmd.wr_prime)
            m_reg <= {k_reg[AW-1:0], 1'b0};
        else if (cmd.wr_mult)
            m_reg <= m_reg + k_reg;
        if (cmd.out_ok)
        begin
            phi_reg <= rdata_reg;
            err_reg <= 1'b0;
        end
        else if (cmd.out_err)
        begin
            phi_reg <= '0;
            err_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            built_reg <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.set_built)
                built_reg <= lim_reg;
            if (cmd.out_ok || cmd.out_err)
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;
        end
    end

    always_comb
    begin
        status.is_query   = op_reg;
        status.lim_zero   = (lim_reg == '0);
        status.idx_bad    = (idx_reg == '0) || (idx_reg > FIELD_W'(built_reg));
        status.k_eq_lim   = (k_reg == {1'b0, lim_reg});
        status.k_le_lim   = (k_reg <= {1'b0, lim_reg});
        status.m_le_lim   = (m_reg <= {1'b0, lim_reg});
        status.rdata_eq_k = (rdata_reg == DATA_W'(k_reg));
        status.div_done   = div_done;
        status.out_free   = !ov_reg || out_ready;
    end

    assign out_valid = ov_reg;
    assign out_phi   = phi_reg;
    assign out_err   = err_reg;

endmodule

`default_nettype wire

### hw/rtl/euler_totient_sieve_unit.sv
// euler_totient_sieve_unit: top level of the totient sieve, stream in and out
// depends on ets_pkg, ets_ctrl, ets_dp (which uses ets_div)
//
// A build transaction (tuser 0) fills a table with phi(k) for k = 1..limit,
// limit saturated to MAX_N, and returns phi(limit); limit 0 clears the built
// range and returns out_of_range. A query transaction (tuser 1) returns the
// stored phi(index), or 0 with out_of_range when index is 0 or above the
// last built limit. One item is in work at a time. A query reads the
// table in the decide state. A build writes k to each entry, then scans
// each index from 2 and, for each prime, updates the entry of every
// multiple with the one-bit-per-cycle divider. A result waits in an
// output register; the next item is taken once it is staged.
`default_nettype none

module euler_totient_sieve_unit
    import ets_pkg::*;
#(
    parameter int MAX_N = 1023
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,  // limit[9:0], index[19:10], zero pad
    input  wire logic        s_axis_tuser,  // operation
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,  // phi_value[9:0], zero pad
    output logic             m_axis_tuser   // out_of_range
);

    localparam int FIELD_MAX = (1 << FIELD_W) - 1;
    localparam int LIM_MAX   = (MAX_N < FIELD_MAX) ? MAX_N : FIELD_MAX;

    ets_cmd_t          cmd;
    ets_status_t       status;
    logic [DATA_W-1:0] phi;

    ets_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ets_dp #(
        .LIM_MAX (LIM_MAX)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_op     (s_axis_tuser),
        .in_limit  (s_axis_tdata[FIELD_W-1:0]),
        .in_index  (s_axis_tdata[2*FIELD_W-1:FIELD_W]),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_phi   (phi),
        .out_err   (m_axis_tuser)
    );

    assign m_axis_tdata = {(16 - DATA_W)'(0), phi};

endmodule

`default_nettype wire
